>>> hw/rtl/ktrf_pkg.sv
// Shared types and constants for the trigram repeat finder.
// Used by the front end, back end, top level and checker.
package ktrf_pkg;

    localparam int SYMBOL_BITS   = 8;
    localparam int OUT_KEY_BITS  = 24;
    localparam int OUT_POS_BITS  = 16;
    localparam int COUNT_BITS    = 16;
    localparam int EXT_KEY_BITS  = 64;
    localparam int EXT_POS_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    typedef struct packed {
        logic [SYMBOL_BITS-1:0] symbol;
        logic                   start_text;
    } t_in_item;

    typedef struct packed {
        logic [OUT_KEY_BITS-1:0] trigram_key;
        logic [OUT_POS_BITS-1:0] repeat_position;
        logic [OUT_POS_BITS-1:0] first_position;
        logic [OUT_POS_BITS-1:0] repeat_distance;
        logic [COUNT_BITS-1:0]   occurrence_count;
        logic                    table_overflow;
    } t_out_item;

    typedef struct packed {
        logic clear;
        logic gram;
        logic pos_ovf;
    } t_cmd_flags;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } t_back_state;

endpackage

>>> hw/rtl/ktrf_front.sv
// Front end: byte history, position counter and gram formation.
// Depends on ktrf_pkg; feeds commands into the command queue.
module ktrf_front #(
    parameter int POSITION_BITS = 16,
    parameter int GRAM_LENGTH   = 3
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  ktrf_pkg::t_in_item                   i_item,
    input  logic                                 i_q_full,
    output logic                                 o_q_wr,
    output ktrf_pkg::t_cmd_flags                 o_flags,
    output logic [8*GRAM_LENGTH-1:0]             o_key,
    output logic [POSITION_BITS-1:0]             o_start
);
    import ktrf_pkg::*;

    localparam int HIST_W = SYMBOL_BITS * (GRAM_LENGTH - 1);
    localparam int KEY_W  = SYMBOL_BITS * GRAM_LENGTH;
    localparam int SEEN_W = POSITION_BITS + 1;
    localparam logic [SEEN_W-1:0] LAG        = SEEN_W'(GRAM_LENGTH - 1);
    localparam logic [SEEN_W-1:0] SEEN_LIMIT = {1'b0, {POSITION_BITS{1'b1}}}
                                               + SEEN_W'(GRAM_LENGTH);

    logic [HIST_W-1:0] r_hist, n_hist, hist_eff;
    logic [SEEN_W-1:0] r_seen, n_seen, seen_eff, start_full;
    logic [KEY_W-1:0]  key;
    logic              accept, gram, pos_ovf;

    always_comb begin
        accept     = i_push && !i_q_full;
        hist_eff   = i_item.start_text ? '0 : r_hist;
        seen_eff   = i_item.start_text ? '0 : r_seen;
        key        = {hist_eff, i_item.symbol};
        gram       = seen_eff >= LAG;
        start_full = seen_eff - LAG;
        pos_ovf    = gram && start_full[POSITION_BITS];
        n_hist     = key[HIST_W-1:0];
        n_seen     = seen_eff;
        if (!gram || (seen_eff < SEEN_LIMIT)) begin
            n_seen = seen_eff + SEEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_seen <= '0;
        end else if (accept) begin
            r_hist <= n_hist;
            r_seen <= n_seen;
        end
    end

    assign o_q_wr          = accept;
    assign o_flags.clear   = i_item.start_text;
    assign o_flags.gram    = gram;
    assign o_flags.pos_ovf = pos_ovf;
    assign o_key           = key;
    assign o_start         = pos_ovf ? '1 : start_full[POSITION_BITS-1:0];

endmodule

>>> hw/rtl/ktrf_cmdq.sv
// Short command queue between the front end and the back end.
// Register-based circular buffer; no package dependency.
module ktrf_cmdq #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full  = r_cnt == CW'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + PW'(1);
            end
            if (rd_en) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

>>> hw/rtl/ktrf_back.sv
// Back end: slot table memory, sequential key scan, insert and result register.
// Depends on ktrf_pkg; consumes commands from the command queue.
module ktrf_back #(
    parameter int TRIGRAM_SLOTS = 1024,
    parameter int POSITION_BITS = 16,
    parameter int GRAM_LENGTH   = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_empty,
    input  ktrf_pkg::t_cmd_flags         i_flags,
    input  logic [8*GRAM_LENGTH-1:0]     i_key,
    input  logic [POSITION_BITS-1:0]     i_start,
    output logic                         o_q_rd,
    input  logic                         i_pop,
    output logic                         o_empty,
    output ktrf_pkg::t_out_item          o_result
);
    import ktrf_pkg::*;

    localparam int KEY_W = SYMBOL_BITS * GRAM_LENGTH;
    localparam int IW    = $clog2(TRIGRAM_SLOTS);
    localparam int CW    = $clog2(TRIGRAM_SLOTS + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(TRIGRAM_SLOTS);

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic [POSITION_BITS-1:0] first;
        logic [COUNT_BITS-1:0]    count;
    } t_slot;

    t_slot                    r_mem [TRIGRAM_SLOTS];
    t_slot                    r_rd;
    t_back_state              r_state, n_state;
    logic [CW-1:0]            r_fill, n_fill, r_idx, n_idx;
    logic [IW-1:0]            r_cmp_idx, n_cmp_idx;
    logic                     r_pend, n_pend, r_ovf, n_ovf, r_out_vld, n_out_vld;
    logic [KEY_W-1:0]         r_key, n_key;
    logic [POSITION_BITS-1:0] r_start, n_start, rep_dist;
    t_out_item                r_out, n_out;
    logic                     issue, hit, rd_en, mem_we;
    logic [IW-1:0]            mem_waddr;
    t_slot                    mem_wdata;
    logic [COUNT_BITS-1:0]    cnt_inc;
    logic [EXT_KEY_BITS-1:0]  key_ext;
    logic [EXT_POS_BITS-1:0]  start_ext, first_ext, dist_ext;

    always_comb begin
        issue     = r_idx < r_fill;
        hit       = r_pend && (r_rd.key == r_key);
        cnt_inc   = (r_rd.count == COUNT_MAX) ? COUNT_MAX : r_rd.count + COUNT_ONE;
        rep_dist  = r_start - r_rd.first;
        key_ext   = EXT_KEY_BITS'(r_key);
        start_ext = EXT_POS_BITS'(r_start);
        first_ext = EXT_POS_BITS'(r_rd.first);
        dist_ext  = EXT_POS_BITS'(rep_dist);

        n_state   = r_state;
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_cmp_idx = r_cmp_idx;
        n_pend    = r_pend;
        n_ovf     = r_ovf;
        n_key     = r_key;
        n_start   = r_start;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;
        o_q_rd    = 1'b0;
        rd_en     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_cmp_idx;
        mem_wdata = r_rd;

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && !r_out_vld) begin
                    o_q_rd = 1'b1;
                    if (i_flags.clear) begin
                        n_fill = '0;
                    end
                    n_ovf = (r_ovf && !i_flags.clear) || i_flags.pos_ovf;
                    if (i_flags.gram) begin
                        n_key   = i_key;
                        n_start = i_start;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                rd_en     = issue;
                n_pend    = issue && !hit;
                n_cmp_idx = r_idx[IW-1:0];
                if (issue) begin
                    n_idx = r_idx + CW'(1);
                end
                if (hit) begin
                    mem_we                 = 1'b1;
                    mem_waddr              = r_cmp_idx;
                    mem_wdata              = '{key: r_rd.key, first: r_rd.first,
                                               count: cnt_inc};
                    n_out.trigram_key      = key_ext[OUT_KEY_BITS-1:0];
                    n_out.repeat_position  = start_ext[OUT_POS_BITS-1:0];
                    n_out.first_position   = first_ext[OUT_POS_BITS-1:0];
                    n_out.repeat_distance  = dist_ext[OUT_POS_BITS-1:0];
                    n_out.occurrence_count = cnt_inc;
                    n_out.table_overflow   = r_ovf;
                    n_out_vld              = 1'b1;
                    n_state                = ST_IDLE;
                end else if (!r_pend && !issue) begin
                    if (r_fill != FILL_MAX) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_fill[IW-1:0];
                        mem_wdata = '{key: r_key, first: r_start, count: COUNT_ONE};
                        n_fill    = r_fill + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd <= r_mem[r_idx[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_pend    <= n_pend;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= n_cmp_idx;
        r_key     <= n_key;
        r_start   <= n_start;
        r_out     <= n_out;
    end

    assign o_empty  = !r_out_vld;
    assign o_result = r_out;

endmodule

>>> hw/rtl/kasiski_trigram_repeat_finder_top.sv
// Trigram repeat finder. A byte is taken into a two-deep command queue when it is not full.
// A gram is looked up by scanning the F filled slots of the table memory over one
// read port, in slot order up to the first hit; the back end holds while a result waits.
// Bytes that complete no gram leave the queue without a scan. Sustained rate is set by the scan.
// Synchronous active-low reset empties queue, fill count and result register; no clearing pass.
module kasiski_trigram_repeat_finder_top #(
    parameter int TRIGRAM_SLOTS = 1024,
    parameter int POSITION_BITS = 16,
    parameter int GRAM_LENGTH   = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  ktrf_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output ktrf_pkg::t_out_item o_result
);
    import ktrf_pkg::*;

    localparam int KEY_W = SYMBOL_BITS * GRAM_LENGTH;
    localparam int FL_W  = $bits(t_cmd_flags);
    localparam int Q_W   = FL_W + KEY_W + POSITION_BITS;

    t_cmd_flags               f_flags, b_flags;
    logic [KEY_W-1:0]         f_key, b_key;
    logic [POSITION_BITS-1:0] f_start, b_start;
    logic [Q_W-1:0]           q_wdata, q_rdata;
    logic                     q_wr, q_rd, q_full, q_empty;

    ktrf_front #(
        .POSITION_BITS (POSITION_BITS),
        .GRAM_LENGTH   (GRAM_LENGTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_flags  (f_flags),
        .o_key    (f_key),
        .o_start  (f_start)
    );

    assign q_wdata = {f_flags, f_key, f_start};

    ktrf_cmdq #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_empty (q_empty)
    );

    assign {b_flags, b_key, b_start} = q_rdata;

    ktrf_back #(
        .TRIGRAM_SLOTS (TRIGRAM_SLOTS),
        .POSITION_BITS (POSITION_BITS),
        .GRAM_LENGTH   (GRAM_LENGTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_flags   (b_flags),
        .i_key     (b_key),
        .i_start   (b_start),
        .o_q_rd    (q_rd),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    assign full = q_full;

endmodule

>>> hw/rtl/ktrf_checker.sv
// Port-level checks for the trigram repeat finder, bound to the top level.
// Depends on ktrf_pkg.
module ktrf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input ktrf_pkg::t_out_item o_result
);
    import ktrf_pkg::*;

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending right after reset");

    a_not_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("input blocked right after reset");

    a_count_at_least_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.occurrence_count >= COUNT_BITS'(2)))
        else $error("repeat reported with count below two");

    a_distance_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.repeat_distance ==
                    OUT_POS_BITS'(o_result.repeat_position - o_result.first_position)))
        else $error("repeat distance disagrees with positions");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind kasiski_trigram_repeat_finder_top ktrf_checker u_ktrf_checker (.*);

>>> test/kasiski_trigram_checker.sv
// Scoreboard for the trigram repeat finder: tracks the gram table from accepted input beats
// and checks each popped result, field by field, against the oldest predicted repeat.
// Depends on ktrf_pkg for the beat types and the count limits.
module kasiski_trigram_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic                i_full,
    input  ktrf_pkg::t_in_item  i_item,
    input  logic                i_empty,
    input  logic                i_pop,
    input  ktrf_pkg::t_out_item i_result,
    output int                  o_mismatches,
    output int                  o_outstanding,
    output int                  o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ktrf_pkg::*;

    localparam int SLOTS   = 1024;
    localparam int POS_MAX = 65535;
    localparam int LAG     = 2;

    logic [15:0] history;
    int          bytes_taken;
    logic [23:0] gram_key   [SLOTS];
    logic [15:0] gram_first [SLOTS];
    logic [15:0] gram_count [SLOTS];
    int          slots_filled;
    logic        dropped;

    t_out_item   repeats_due[$];
    int          mismatches = 0;
    int          checked = 0;
    int          shown = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = repeats_due.size();
    assign o_checked     = checked;

    task automatic clear_text();
        history      = '0;
        bytes_taken  = 0;
        slots_filled = 0;
        dropped      = 1'b0;
    endtask

    task automatic track_trigram(input t_in_item beat);
        logic [23:0] key;
        int          start;
        int          hit;
        int          k;
        t_out_item   rep;
        if (beat.start_text) clear_text();
        key     = {history, beat.symbol};
        history = key[15:0];
        if (bytes_taken < LAG) begin
            bytes_taken++;
            return;
        end
        start = bytes_taken - LAG;
        if (start > POS_MAX) begin
            start   = POS_MAX;
            dropped = 1'b1;
        end
        if (bytes_taken < POS_MAX + 3) bytes_taken++;
        hit = -1;
        k   = 0;
        while (k < slots_filled && hit < 0) begin
            if (gram_key[k] == key) hit = k;
            k++;
        end
        if (hit >= 0) begin
            if (gram_count[hit] != COUNT_MAX) gram_count[hit]++;
            rep.trigram_key      = key;
            rep.repeat_position  = start[15:0];
            rep.first_position   = gram_first[hit];
            rep.repeat_distance  = start[15:0] - gram_first[hit];
            rep.occurrence_count = gram_count[hit];
            rep.table_overflow   = dropped;
            repeats_due = {repeats_due, rep};
        end else if (slots_filled < SLOTS) begin
            gram_key[slots_filled]   = key;
            gram_first[slots_filled] = start[15:0];
            gram_count[slots_filled] = COUNT_ONE;
            slots_filled++;
        end else begin
            dropped = 1'b1;
        end
    endtask

    task automatic note_mismatch(input string what, input logic [23:0] want,
                                 input logic [23:0] got);
        mismatches++;
        if (shown < 20) begin
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
            shown++;
        end
    endtask

    task automatic check_report(input t_out_item got);
        t_out_item want;
        checked++;
        if (repeats_due.size() == 0) begin
            mismatches++;
            if (shown < 20) begin
                $display("%0t: unexpected result, expected none actual %h", $time, got);
                shown++;
            end
            return;
        end
        want = repeats_due.pop_front();
        if (got.trigram_key !== want.trigram_key)
            note_mismatch("trigram_key", want.trigram_key, got.trigram_key);
        if (got.repeat_position !== want.repeat_position)
            note_mismatch("repeat_position", 24'(want.repeat_position),
                          24'(got.repeat_position));
        if (got.first_position !== want.first_position)
            note_mismatch("first_position", 24'(want.first_position),
                          24'(got.first_position));
        if (got.repeat_distance !== want.repeat_distance)
            note_mismatch("repeat_distance", 24'(want.repeat_distance),
                          24'(got.repeat_distance));
        if (got.occurrence_count !== want.occurrence_count)
            note_mismatch("occurrence_count", 24'(want.occurrence_count),
                          24'(got.occurrence_count));
        if (got.table_overflow !== want.table_overflow)
            note_mismatch("table_overflow", 24'(want.table_overflow),
                          24'(got.table_overflow));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text();
            repeats_due.delete();
        end else begin
            if (i_push && !i_full) track_trigram(i_item);
            if (i_pop && !i_empty) check_report(i_result);
        end
    end

endmodule

>>> test/tb_kasiski_trigram_repeat_finder_top.sv
// Testbench top for the trigram repeat finder: drives byte beats and pops results
// under several idling mixes, and gives the verdict from the checker's counts.
// Depends on ktrf_pkg, kasiski_trigram_repeat_finder_top and kasiski_trigram_checker.
module tb_kasiski_trigram_repeat_finder_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ktrf_pkg::*;

    localparam int RANDOM_PER_PHASE = 200;
    localparam int SETTLE_CYCLES    = 1100;

    localparam logic [8:0] DIRECTED_BEATS [24] = '{
        9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
        9'h000, 9'h000, 9'h000, 9'h000,
        9'h141, 9'h142,
        9'h041, 9'h042, 9'h043, 9'h041, 9'h042, 9'h043,
        9'h141, 9'h042, 9'h043,
        9'h17F, 9'h07F, 9'h07F, 9'h07F
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      pop = 1'b0;
    logic      full;
    logic      empty;
    t_in_item  i_item = '0;
    t_out_item o_result;

    int idle_pct = 0;
    int stall_pct = 0;
    int beats_sent = 0;
    int random_beats = 0;
    int mismatches;
    int outstanding;
    int checked;

    kasiski_trigram_repeat_finder_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    kasiski_trigram_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_full        (full),
        .i_item        (i_item),
        .i_empty       (empty),
        .i_pop         (pop),
        .i_result      (o_result),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge i_clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send(input logic [7:0] sym, input logic st);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{symbol: sym, start_text: st};
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    // fill every slot with distinct arithmetic grams, overflow, then hit early slots
    task automatic fill_table();
        int steps [5];
        int len;
        steps = '{1, 3, 5, 7, 9};
        for (int seg = 0; seg < 5; seg++) begin
            len = (seg < 4) ? 256 : 20;
            for (int j = 0; j < len; j++)
                send(8'(steps[seg] * j + seg * 17), (seg == 0 && j == 0));
        end
        for (int j = 0; j < 4; j++) send(8'(j), 1'b0);
    endtask

    task automatic send_text();
        int          kind;
        int          len;
        int          span;
        int          period;
        logic [7:0]  base;
        logic [7:0]  sym;
        logic [7:0]  pattern [8];
        kind   = $urandom_range(99);
        base   = 8'($urandom);
        span   = $urandom_range(1, 4);
        period = $urandom_range(2, 8);
        for (int j = 0; j < 8; j++) pattern[j] = 8'($urandom);
        len = (kind < 15) ? $urandom_range(1, 10) : $urandom_range(3, 40);
        for (int j = 0; j < len; j++) begin
            if (kind < 15) begin
                send(8'($urandom), $urandom_range(7) == 0);
            end else begin
                if ($urandom_range(9) == 0)
                    sym = 8'($urandom);
                else if (kind < 50)
                    sym = pattern[j % period];
                else
                    sym = base ^ 8'($urandom_range(span - 1));
                send(sym, j == 0);
            end
            random_beats++;
        end
    endtask

    task automatic random_phase(input int sender_idle, input int receiver_stall);
        int target;
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        target    = random_beats + RANDOM_PER_PHASE;
        while (random_beats < target) send_text();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int j = 0; j < 24; j++) send(DIRECTED_BEATS[j][7:0], DIRECTED_BEATS[j][8]);
        fill_table();
        random_phase(0, 0);
        random_phase(66, 0);
        random_phase(0, 66);
        random_phase(24, 24);
        push      <= 1'b0;
        stall_pct  = 0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Sent %0d byte beats (%0d random) and checked %0d repeat results.",
                 beats_sent, random_beats, checked);
        $display("Covered a full table with overflow, start markers and four idling mixes.");
        if (mismatches == 0 && outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/ktrf_pkg.sv
hw/rtl/ktrf_front.sv
hw/rtl/ktrf_cmdq.sv
hw/rtl/ktrf_back.sv
hw/rtl/kasiski_trigram_repeat_finder_top.sv
hw/rtl/ktrf_checker.sv
test/kasiski_trigram_checker.sv
test/tb_kasiski_trigram_repeat_finder_top.sv
